[rtl/core/rarst_pkg.sv]
// Package for the range add / range sum segment tree unit.
// Holds field widths, opcodes and default sizes; no dependencies.

package rarst_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned IDX_W = 11;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

[rtl/core/rarst_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.

module rarst_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/range_add_range_sum_tree_unit.sv]
// Range add / range sum segment tree with lazy pending adds.
// Depends on rarst_pkg and rarst_ram.
//
// Channel     Dir  Handshake                  Payload
// config      in   cfg_we_i                   element_count_i
// item in     in   in_valid_i / in_ready_o    opcode_i, range_low_i, range_high_i, add_value_i
// result out  out  out_valid_o / out_ready_i  range_sum_o
//
// After reset both stores are cleared, one address a cycle, across all 4*MaxElements addresses.
// An item walks the tree depth first with an explicit stack. A covered node is read and then
// summed for a query or updated for an add; a split node first pushes any pending add to
// both children, and on adds pulls its sum up from them. A shared 32x11 multiplier is used
// twice per node update. An empty range skips the tree walk; a query on it returns zero.
// The unit takes one item at a time; a finished result waits in the output register.

module range_add_range_sum_tree_unit
  import rarst_pkg::*;
#(
  parameter int unsigned MaxElements = MAX_ELEMENTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        element_count_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [IDX_W-1:0]        range_low_i,
  input  logic [IDX_W-1:0]        range_high_i,
  input  logic signed [VAL_W-1:0] add_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SUM_W-1:0] range_sum_o
);

  localparam int unsigned Depth = 4 * MaxElements;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SPW   = $clog2($clog2(MaxElements) + 2);
  localparam int unsigned SD    = 2 ** SPW;
  localparam int unsigned PW    = VAL_W + IDX_W;
  localparam logic [IDX_W-1:0] CountMax =
      (MaxElements > 2047) ? {IDX_W{1'b1}} : IDX_W'(MaxElements);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_ENTER    = 4'd2;
  localparam logic [3:0] ST_CHECK    = 4'd3;
  localparam logic [3:0] ST_AP_RD    = 4'd4;
  localparam logic [3:0] ST_AP_MUL   = 4'd5;
  localparam logic [3:0] ST_AP_WR    = 4'd6;
  localparam logic [3:0] ST_PUSH_CLR = 4'd7;
  localparam logic [3:0] ST_LEFT     = 4'd8;
  localparam logic [3:0] ST_RIGHT    = 4'd9;
  localparam logic [3:0] ST_POST     = 4'd10;
  localparam logic [3:0] ST_PULL_RD0 = 4'd11;
  localparam logic [3:0] ST_PULL_RD1 = 4'd12;
  localparam logic [3:0] ST_PULL_WR  = 4'd13;
  localparam logic [3:0] ST_RET      = 4'd14;
  localparam logic [3:0] ST_FINISH   = 4'd15;

  localparam logic [1:0] AK_COVER = 2'd0;
  localparam logic [1:0] AK_LEFT  = 2'd1;
  localparam logic [1:0] AK_RIGHT = 2'd2;

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0] cfg_q;
  logic             op_q, op_d;
  logic [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [SUM_W-1:0] v_q, v_d;
  logic [AW-1:0]    k_q, k_d;
  logic [IDX_W-1:0] l_q, l_d, r_q, r_d;
  logic [SPW:0]     dp_q, dp_d;
  logic [AW-1:0]    ap_node_q, ap_node_d;
  logic [SUM_W-1:0] ap_val_q, ap_val_d;
  logic [IDX_W-1:0] ap_len_q, ap_len_d;
  logic [1:0]       ap_kind_q, ap_kind_d;
  logic [SUM_W-1:0] prod_q, prod_d;
  logic [SUM_W-1:0] left_q, left_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_sum_q, out_sum_d;

  logic [AW-1:0]    stk_k_q [SD];
  logic [IDX_W-1:0] stk_l_q [SD];
  logic [IDX_W-1:0] stk_r_q [SD];
  logic             stk_ph_q [SD];
  logic             push_en;
  logic             push_ph;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [SUM_W-1:0] sum_rd, pend_rd;
  logic             sum_we, pend_we;
  logic [AW-1:0]    sum_waddr, pend_waddr;
  logic [SUM_W-1:0] sum_wdata, pend_wdata;

  logic [IDX_W-1:0] n_use, lo_c, hi_c;
  logic [IDX_W-1:0] len, mid;
  logic [IDX_W:0]   lr_sum;
  logic             covered;
  logic [AW-1:0]    k2, k2p1;
  logic [VAL_W-1:0] mul_a;
  logic [PW-1:0]    mul_p;
  logic [SPW:0]     dpm1;
  logic [SPW-1:0]   tidx;

  assign n_use = (cfg_q == '0) ? IDX_W'(1)
               : ({21'b0, cfg_q} > MaxElements) ? CountMax : cfg_q;
  assign lo_c  = (range_low_i == '0) ? IDX_W'(1) : range_low_i;
  assign hi_c  = (range_high_i > n_use) ? n_use : range_high_i;

  assign len     = r_q - l_q + IDX_W'(1);
  assign lr_sum  = {1'b0, l_q} + {1'b0, r_q};
  assign mid     = lr_sum[IDX_W:1];
  assign covered = (lo_q <= l_q) && (hi_q >= r_q);
  assign k2      = {k_q[AW-2:0], 1'b0};
  assign k2p1    = {k_q[AW-2:0], 1'b1};
  assign mul_a   = (state_q == ST_AP_RD) ? ap_val_q[VAL_W-1:0] : ap_val_q[SUM_W-1:VAL_W];
  assign mul_p   = PW'(mul_a) * PW'(ap_len_q);
  assign dpm1    = dp_q - 1'b1;
  assign tidx    = dpm1[SPW-1:0];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k_q;
    unique case (state_q)
      ST_ENTER: begin
        rd_en = 1'b1;
      end
      ST_AP_RD: begin
        rd_en   = 1'b1;
        rd_addr = ap_node_q;
      end
      ST_PULL_RD0: begin
        rd_en   = 1'b1;
        rd_addr = k2;
      end
      ST_PULL_RD1: begin
        rd_en   = 1'b1;
        rd_addr = k2p1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    sum_we     = 1'b0;
    pend_we    = 1'b0;
    sum_waddr  = k_q;
    pend_waddr = k_q;
    sum_wdata  = '0;
    pend_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        sum_we     = 1'b1;
        pend_we    = 1'b1;
        sum_waddr  = clr_q;
        pend_waddr = clr_q;
      end
      ST_AP_WR: begin
        sum_we     = 1'b1;
        pend_we    = 1'b1;
        sum_waddr  = ap_node_q;
        pend_waddr = ap_node_q;
        sum_wdata  = sum_rd + prod_q;
        pend_wdata = pend_rd + ap_val_q;
      end
      ST_PUSH_CLR: begin
        pend_we = 1'b1;
      end
      ST_PULL_WR: begin
        sum_we    = 1'b1;
        sum_wdata = left_q + sum_rd;
      end
      default: begin
        sum_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    v_d         = v_q;
    k_d         = k_q;
    l_d         = l_q;
    r_d         = r_q;
    dp_d        = dp_q;
    ap_node_d   = ap_node_q;
    ap_val_d    = ap_val_q;
    ap_len_d    = ap_len_q;
    ap_kind_d   = ap_kind_q;
    prod_d      = prod_q;
    left_d      = left_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    push_en     = 1'b0;
    push_ph     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = opcode_i;
          lo_d  = lo_c;
          hi_d  = hi_c;
          v_d   = SUM_W'(add_value_i);
          k_d   = AW'(1);
          l_d   = IDX_W'(1);
          r_d   = n_use;
          dp_d  = '0;
          acc_d = '0;
          if (lo_c > hi_c) begin
            state_d = (opcode_i == OP_QUERY) ? ST_FINISH : ST_IDLE;
          end else begin
            state_d = ST_ENTER;
          end
        end
      end
      ST_ENTER: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (covered) begin
          if (op_q == OP_QUERY) begin
            acc_d   = acc_q + sum_rd;
            state_d = ST_RET;
          end else begin
            ap_node_d = k_q;
            ap_val_d  = v_q;
            ap_len_d  = len;
            ap_kind_d = AK_COVER;
            state_d   = ST_AP_RD;
          end
        end else if (pend_rd != '0) begin
          ap_node_d = k2;
          ap_val_d  = pend_rd;
          ap_len_d  = len - (len >> 1);
          ap_kind_d = AK_LEFT;
          state_d   = ST_AP_RD;
        end else begin
          state_d = ST_LEFT;
        end
      end
      ST_AP_RD: begin
        prod_d  = SUM_W'(mul_p);
        state_d = ST_AP_MUL;
      end
      ST_AP_MUL: begin
        prod_d  = prod_q + {mul_p[VAL_W-1:0], {VAL_W{1'b0}}};
        state_d = ST_AP_WR;
      end
      ST_AP_WR: begin
        unique case (ap_kind_q)
          AK_COVER: begin
            state_d = ST_RET;
          end
          AK_LEFT: begin
            ap_node_d = k2p1;
            ap_len_d  = len >> 1;
            ap_kind_d = AK_RIGHT;
            state_d   = ST_AP_RD;
          end
          default: begin
            state_d = ST_PUSH_CLR;
          end
        endcase
      end
      ST_PUSH_CLR: begin
        state_d = ST_LEFT;
      end
      ST_LEFT: begin
        if (lo_q <= mid) begin
          push_en = 1'b1;
          push_ph = 1'b0;
          dp_d    = dp_q + 1'b1;
          k_d     = k2;
          r_d     = mid;
          state_d = ST_ENTER;
        end else begin
          state_d = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        if (hi_q > mid) begin
          push_en = 1'b1;
          push_ph = 1'b1;
          dp_d    = dp_q + 1'b1;
          k_d     = k2p1;
          l_d     = mid + IDX_W'(1);
          state_d = ST_ENTER;
        end else begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = (op_q == OP_ADD) ? ST_PULL_RD0 : ST_RET;
      end
      ST_PULL_RD0: begin
        state_d = ST_PULL_RD1;
      end
      ST_PULL_RD1: begin
        left_d  = sum_rd;
        state_d = ST_PULL_WR;
      end
      ST_PULL_WR: begin
        state_d = ST_RET;
      end
      ST_RET: begin
        if (dp_q == '0) begin
          state_d = (op_q == OP_QUERY) ? ST_FINISH : ST_IDLE;
        end else begin
          dp_d    = dpm1;
          k_d     = stk_k_q[tidx];
          l_d     = stk_l_q[tidx];
          r_d     = stk_r_q[tidx];
          state_d = stk_ph_q[tidx] ? ST_POST : ST_RIGHT;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cfg_q       <= CountMax;
      dp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      dp_q        <= dp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= element_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    v_q       <= v_d;
    k_q       <= k_d;
    l_q       <= l_d;
    r_q       <= r_d;
    ap_node_q <= ap_node_d;
    ap_val_q  <= ap_val_d;
    ap_len_q  <= ap_len_d;
    ap_kind_q <= ap_kind_d;
    prod_q    <= prod_d;
    left_q    <= left_d;
    acc_q     <= acc_d;
    out_sum_q <= out_sum_d;
    if (push_en) begin
      stk_k_q[dp_q[SPW-1:0]]  <= k_q;
      stk_l_q[dp_q[SPW-1:0]]  <= l_q;
      stk_r_q[dp_q[SPW-1:0]]  <= r_q;
      stk_ph_q[dp_q[SPW-1:0]] <= push_ph;
    end
  end

  rarst_ram #(
    .Width(SUM_W),
    .Depth(Depth)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(sum_rd)
  );

  rarst_ram #(
    .Width(SUM_W),
    .Depth(Depth)
  ) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(pend_waddr),
    .wdata_i(pend_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(pend_rd)
  );

endmodule

[rtl/core/rarst_checker.sv]
// Port-level checker for the range add / range sum tree unit, with its bind.
// Depends on rarst_pkg.

module rarst_checker
  import rarst_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    opcode_i,
  input logic [IDX_W-1:0]        range_low_i,
  input logic [IDX_W-1:0]        range_high_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [SUM_W-1:0] range_sum_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(range_sum_o)))
    else $error("Result item changed or dropped while stalled.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_QUERY) |=> !in_ready_o)
    else $error("Unit ready again right after taking an item.");

  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_ADD && !out_valid_o) |=> !out_valid_o)
    else $error("Add item produced a result.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_QUERY && range_low_i != '0 && range_low_i > range_high_i
     && !out_valid_o) |=> ##1 (out_valid_o && range_sum_o == '0))
    else $error("Empty range query did not return zero.");

endmodule

bind range_add_range_sum_tree_unit rarst_checker u_rarst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .opcode_i    (opcode_i),
  .range_low_i (range_low_i),
  .range_high_i(range_high_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .range_sum_o (range_sum_o)
);
